// ----- hw/rtl/bsrc_pkg.sv -----
// shared constants and codes of the banker's safety and request check block
package bsrc_pkg;

   // default sizes
   localparam int MaxProcessesDef = 8;
   localparam int MaxResourcesDef = 4;
   localparam int CountWidthDef   = 16;

   // fixed field widths
   localparam int ModeW   = 3;
   localparam int ProcW   = 3;
   localparam int ResW    = 2;
   localparam int AmountW = 16;
   localparam int StatusW = 4;
   localparam int CsrIdxW = 1;
   localparam int CsrDatW = 4;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_PROCESS_COUNT  = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_RESOURCE_COUNT = 1'd1;

   // register reset values
   localparam logic [3:0] PROCESS_COUNT_RST  = 4'd8;
   localparam logic [2:0] RESOURCE_COUNT_RST = 3'd4;

   // modes
   localparam logic [ModeW-1:0] MODE_LOAD_AVAIL = 3'd0;
   localparam logic [ModeW-1:0] MODE_LOAD_ALLOC = 3'd1;
   localparam logic [ModeW-1:0] MODE_LOAD_REQ   = 3'd2;
   localparam logic [ModeW-1:0] MODE_SUBMIT     = 3'd3;
   localparam logic [ModeW-1:0] MODE_CHECK      = 3'd4;

   // status codes
   localparam logic [StatusW-1:0] ST_LOADED   = 4'd0;
   localparam logic [StatusW-1:0] ST_REJECTED = 4'd1;
   localparam logic [StatusW-1:0] ST_SEQ      = 4'd2;
   localparam logic [StatusW-1:0] ST_SAFE     = 4'd3;
   localparam logic [StatusW-1:0] ST_UNSAFE   = 4'd4;
   localparam logic [StatusW-1:0] ST_GRANTED  = 4'd5;
   localparam logic [StatusW-1:0] ST_EXCEEDS  = 4'd6;
   localparam logic [StatusW-1:0] ST_WAIT     = 4'd7;
   localparam logic [StatusW-1:0] ST_DENIED   = 4'd8;
   localparam logic [StatusW-1:0] ST_BAD_PROC = 4'd9;

endpackage

// ----- hw/rtl/bsrc_req_if.sv -----
// request channel interface
interface bsrc_req_if;
   logic                        valid;
   logic                        ready;
   logic [bsrc_pkg::ModeW-1:0]   mode;
   logic [bsrc_pkg::ProcW-1:0]   process_index;
   logic [bsrc_pkg::ResW-1:0]    resource_index;
   logic [bsrc_pkg::AmountW-1:0] amount;
   logic [bsrc_pkg::AmountW-1:0] max_claim;

   modport source (output valid, mode, process_index, resource_index, amount, max_claim,
                   input ready);
   modport sink (input valid, mode, process_index, resource_index, amount, max_claim,
                 output ready);
endinterface

// ----- hw/rtl/bsrc_rsp_if.sv -----
// response channel interface
interface bsrc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bsrc_pkg::StatusW-1:0] status;
   logic [bsrc_pkg::ProcW-1:0]   process_out;
   logic                        last;

   modport source (output valid, status, process_out, last, input ready);
   modport sink (input valid, status, process_out, last, output ready);
endinterface

// ----- hw/rtl/bsrc_fit_unit.sv -----
// shared compare and accumulate unit: one process row against the work vector
module bsrc_fit_unit #(
   parameter int MAX_RESOURCES = bsrc_pkg::MaxResourcesDef,
   parameter int COUNT_WIDTH   = bsrc_pkg::CountWidthDef,
   parameter int WORK_WIDTH    = bsrc_pkg::CountWidthDef + 4
) (
   input  logic [COUNT_WIDTH-1:0] need_row  [MAX_RESOURCES],
   input  logic [COUNT_WIDTH-1:0] alloc_row [MAX_RESOURCES],
   input  logic [WORK_WIDTH-1:0]  work      [MAX_RESOURCES],
   input  logic [MAX_RESOURCES-1:0] res_mask,
   output logic                   fits,
   output logic [WORK_WIDTH-1:0]  work_next [MAX_RESOURCES]
);

   // per resource compare and add, all lanes at once
   always_comb begin
      fits = 1'b1;
      for (int i = 0; i < MAX_RESOURCES; i++) begin
         if (res_mask[i] && (WORK_WIDTH'(need_row[i]) > work[i])) begin
            fits = 1'b0;
         end
         work_next[i] = res_mask[i] ? work[i] + WORK_WIDTH'(alloc_row[i]) : work[i];
      end
   end

endmodule

// ----- hw/rtl/bankers_safety_and_request_check_core.sv -----
// top level: tables, sequencer and response register of the banker's check
//
// Usage: items arrive on req_ch (valid/ready), results leave on rsp_ch.
// Loads (modes 0, 1, 2) answer with one word, set in the response register from
// the EXEC state once that register is free; then req_ch.ready rises again.
// A submit (mode 3) checks the buffered request against need and available,
// then runs the safety check on the tentatively granted state; a check
// (mode 4) runs it on the present state. The safety check visits one process
// per cycle through a single compare/add unit, pass after pass, unless a
// finished process waits for a busy response register, which holds the scan.
// Every finished process leaves as one sequence word, then a verdict word
// flagged last. Unknown modes give no word. One item is in work at a time;
// req_ch.ready is low until its last word is in the response register.
// A stalled receiver holds the response register; the sequencer waits when it has a word for it.
// Reset (synchronous, active high) clears all tables and sets the counts to
// 8 and 4, the default maxima. csr_we writes process_count (index 0) or
// resource_count (index 1) and must only be used while the block is idle.
module bankers_safety_and_request_check_core #(
   parameter int MAX_PROCESSES = bsrc_pkg::MaxProcessesDef,
   parameter int MAX_RESOURCES = bsrc_pkg::MaxResourcesDef,
   parameter int COUNT_WIDTH   = bsrc_pkg::CountWidthDef
) (
   input  logic                         clock,
   input  logic                         reset,
   bsrc_req_if.sink                     req_ch,
   bsrc_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [bsrc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [bsrc_pkg::CsrDatW-1:0] csr_wdata
);
   import bsrc_pkg::*;

   localparam int PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RIW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int NPW = $clog2(MAX_PROCESSES + 1);
   localparam int NRW = $clog2(MAX_RESOURCES + 1);
   localparam int WW  = COUNT_WIDTH + NPW;

   typedef enum logic [1:0] {IDLE, EXEC, SCAN, VERDICT} state_type;

   state_type state_ff;

   // configuration
   logic [3:0] pcount_ff;
   logic [2:0] rcount_ff;

   // tables
   logic [COUNT_WIDTH-1:0] avail_ff [MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] reqv_ff  [MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] alloc_ff [MAX_PROCESSES][MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] need_ff  [MAX_PROCESSES][MAX_RESOURCES];

   // latched item
   logic [ModeW-1:0]       mode_ff;
   logic [ProcW-1:0]       pidx_ff;
   logic [ResW-1:0]        ridx_ff;
   logic [COUNT_WIDTH-1:0] amt_ff;
   logic [COUNT_WIDTH-1:0] claim_ff;

   // safety check state
   logic [WW-1:0]            work_ff [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] fin_ff;
   logic [PIW-1:0]           scan_ff;
   logic [NPW-1:0]           count_ff;
   logic                     found_ff;
   logic                     tent_ff;
   logic                     safe_ff;

   // response register
   logic               rsp_valid_ff;
   logic [StatusW-1:0] rsp_status_ff;
   logic [ProcW-1:0]   rsp_proc_ff;
   logic               rsp_last_ff;

   // effective counts and resource mask
   logic [NPW-1:0]           np;
   logic [NRW-1:0]           nr;
   logic [MAX_RESOURCES-1:0] res_mask;
   logic [PIW-1:0]           prow;
   logic [RIW-1:0]           rcol;
   logic                     r_bad;
   logic                     p_bad;
   logic                     over_need;
   logic                     over_avail;
   logic                     slot_free;

   always_comb begin
      np = (32'(pcount_ff) > MAX_PROCESSES) ? NPW'(MAX_PROCESSES) : NPW'(pcount_ff);
      nr = (32'(rcount_ff) > MAX_RESOURCES) ? NRW'(MAX_RESOURCES) : NRW'(rcount_ff);
      for (int i = 0; i < MAX_RESOURCES; i++) begin
         res_mask[i] = i < 32'(nr);
      end
      prow       = PIW'(pidx_ff);
      rcol       = RIW'(ridx_ff);
      r_bad      = 32'(ridx_ff) >= 32'(nr);
      p_bad      = 32'(pidx_ff) >= 32'(np);
      over_need  = 1'b0;
      over_avail = 1'b0;
      for (int i = 0; i < MAX_RESOURCES; i++) begin
         if (res_mask[i] && reqv_ff[i] > need_ff[prow][i]) over_need = 1'b1;
         if (res_mask[i] && reqv_ff[i] > avail_ff[i]) over_avail = 1'b1;
      end
      slot_free = !rsp_valid_ff || rsp_ch.ready;
   end

   // row under scan, with the tentative grant folded in
   logic [COUNT_WIDTH-1:0] need_row  [MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0] alloc_row [MAX_RESOURCES];
   logic                   is_sub_row;

   always_comb begin
      is_sub_row = tent_ff && (scan_ff == prow);
      for (int i = 0; i < MAX_RESOURCES; i++) begin
         need_row[i]  = is_sub_row ? need_ff[scan_ff][i] - reqv_ff[i] : need_ff[scan_ff][i];
         alloc_row[i] = is_sub_row ? alloc_ff[scan_ff][i] + reqv_ff[i] : alloc_ff[scan_ff][i];
      end
   end

   logic          fits;
   logic [WW-1:0] work_next [MAX_RESOURCES];

   bsrc_fit_unit #(
      .MAX_RESOURCES(MAX_RESOURCES),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .WORK_WIDTH   (WW)
   ) u_fit (
      .need_row (need_row),
      .alloc_row(alloc_row),
      .work     (work_ff),
      .res_mask (res_mask),
      .fits     (fits),
      .work_next(work_next)
   );

   // scan step decode
   logic           take;
   logic           advance;
   logic [NPW-1:0] count_now;
   logic           found_now;
   logic           pass_end;

   always_comb begin
      take      = !fin_ff[scan_ff] && fits;
      advance   = !take || slot_free;
      count_now = count_ff + NPW'(take);
      found_now = found_ff || take;
      pass_end  = 32'(scan_ff) == 32'(np) - 1;
   end

   assign req_ch.ready       = (state_ff == IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.process_out = rsp_proc_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // sequencer, tables and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pcount_ff    <= PROCESS_COUNT_RST;
         rcount_ff    <= RESOURCE_COUNT_RST;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= '0;
         scan_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         tent_ff      <= 1'b0;
         safe_ff      <= 1'b0;
         for (int i = 0; i < MAX_RESOURCES; i++) begin
            avail_ff[i] <= '0;
            reqv_ff[i]  <= '0;
            work_ff[i]  <= '0;
            for (int q = 0; q < MAX_PROCESSES; q++) begin
               alloc_ff[q][i] <= '0;
               need_ff[q][i]  <= '0;
            end
         end
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;

         // register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_PROCESS_COUNT:  pcount_ff <= csr_wdata;
               CSR_RESOURCE_COUNT: rcount_ff <= csr_wdata[2:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            IDLE: begin
               if (req_ch.valid) begin
                  mode_ff  <= req_ch.mode;
                  pidx_ff  <= req_ch.process_index;
                  ridx_ff  <= req_ch.resource_index;
                  amt_ff   <= COUNT_WIDTH'(req_ch.amount);
                  claim_ff <= COUNT_WIDTH'(req_ch.max_claim);
                  state_ff <= EXEC;
               end
            end
            EXEC: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_proc_ff   <= '0;
                  rsp_last_ff   <= 1'b1;
                  rsp_status_ff <= ST_LOADED;
                  state_ff      <= IDLE;
                  for (int i = 0; i < MAX_RESOURCES; i++) begin
                     work_ff[i] <= res_mask[i]
                                   ? WW'(avail_ff[i] - (mode_ff == MODE_SUBMIT ? reqv_ff[i] : '0))
                                   : '0;
                  end
                  fin_ff   <= '0;
                  scan_ff  <= '0;
                  count_ff <= '0;
                  found_ff <= 1'b0;
                  safe_ff  <= 1'b1;
                  tent_ff  <= (mode_ff == MODE_SUBMIT);
                  unique case (mode_ff)
                     MODE_LOAD_AVAIL, MODE_LOAD_REQ: begin
                        if (r_bad) begin
                           rsp_status_ff <= ST_REJECTED;
                        end else if (mode_ff == MODE_LOAD_AVAIL) begin
                           avail_ff[rcol] <= amt_ff;
                        end else begin
                           reqv_ff[rcol] <= amt_ff;
                        end
                     end
                     MODE_LOAD_ALLOC: begin
                        if (r_bad || p_bad || claim_ff < amt_ff) begin
                           rsp_status_ff <= ST_REJECTED;
                        end else begin
                           alloc_ff[prow][rcol] <= amt_ff;
                           need_ff[prow][rcol]  <= claim_ff - amt_ff;
                        end
                     end
                     MODE_SUBMIT: begin
                        if (p_bad) begin
                           rsp_status_ff <= ST_BAD_PROC;
                        end else if (over_need) begin
                           rsp_status_ff <= ST_EXCEEDS;
                        end else if (over_avail) begin
                           rsp_status_ff <= ST_WAIT;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= (np == '0) ? VERDICT : SCAN;
                        end
                     end
                     MODE_CHECK: begin
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= (np == '0) ? VERDICT : SCAN;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b0;
                     end
                  endcase
               end
            end
            SCAN: begin
               if (advance) begin
                  if (take) begin
                     work_ff         <= work_next;
                     fin_ff[scan_ff] <= 1'b1;
                     rsp_valid_ff    <= 1'b1;
                     rsp_status_ff   <= ST_SEQ;
                     rsp_proc_ff     <= ProcW'(scan_ff);
                     rsp_last_ff     <= 1'b0;
                  end
                  count_ff <= count_now;
                  if (pass_end) begin
                     scan_ff  <= '0;
                     found_ff <= 1'b0;
                     if (count_now == np) begin
                        safe_ff  <= 1'b1;
                        state_ff <= VERDICT;
                     end else if (!found_now) begin
                        safe_ff  <= 1'b0;
                        state_ff <= VERDICT;
                     end
                  end else begin
                     scan_ff  <= scan_ff + PIW'(1);
                     found_ff <= found_now;
                  end
               end
            end
            VERDICT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_proc_ff  <= '0;
                  rsp_last_ff  <= 1'b1;
                  if (tent_ff) begin
                     rsp_status_ff <= safe_ff ? ST_GRANTED : ST_DENIED;
                  end else begin
                     rsp_status_ff <= safe_ff ? ST_SAFE : ST_UNSAFE;
                  end
                  // commit the grant
                  if (tent_ff && safe_ff) begin
                     for (int i = 0; i < MAX_RESOURCES; i++) begin
                        if (res_mask[i]) begin
                           avail_ff[i]       <= avail_ff[i] - reqv_ff[i];
                           alloc_ff[prow][i] <= alloc_ff[prow][i] + reqv_ff[i];
                           need_ff[prow][i]  <= need_ff[prow][i] - reqv_ff[i];
                        end
                     end
                  end
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // finish bits only grow while scanning
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN && $past(state_ff == SCAN)) |-> (($past(fin_ff) & ~fin_ff) == '0))
      else $error("finish bit dropped during safety check");

   // finished count tracks the finish bits
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> (32'(count_ff) == $countones(fin_ff)))
      else $error("finished count out of step with finish bits");

   // sequence words are never last
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_SEQ) |-> !rsp_last_ff)
      else $error("sequence word flagged last");

   // a verdict word is always last
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == VERDICT) && state_ff == IDLE) |-> (rsp_valid_ff && rsp_last_ff))
      else $error("verdict left without a last word");

endmodule
